/* rtl/core/sete_pkg.sv */
// Package for the sprite entry tile expander: state codes, field positions
// and the sideband record that travels with each tile read.
// No dependencies.
package sete_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_EMIT
    } sete_state_t;

    localparam int INDEX_BITS = 16;
    localparam int CODE_BITS  = 16;
    localparam int POS_BITS   = 9;
    localparam int SIZE_BITS  = 3;
    localparam int COLOR_BITS = 6;
    localparam int IN_BITS    = 96;
    localparam int OUT_BITS   = 48;

    localparam logic [POS_BITS-1:0] TILE_STEP = 9'd16;

    typedef struct packed {
        logic [COLOR_BITS-1:0] colour;
        logic                  flip_x;
        logic [POS_BITS-1:0]   x_pos;
        logic [POS_BITS-1:0]   y_pos;
        logic                  last;
    } tile_side_t;

endpackage

/* rtl/core/sete_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module sete_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/core/sprite_entry_tile_expander_core.sv */
// Sprite entry tile expander top level: tile-code redirect table and the
// sequencer that expands one sprite entry into tile draw commands.
// Depends on sete_pkg and sete_ram.
//
// The slave channel takes one request at a time. With tuser low the request
// writes one redirect table entry; with tuser high it expands a sprite entry
// into width*height tile commands on the master channel, tlast marking the
// final command of the entry. Every request first reduces its table index
// modulo TABLE_ENTRIES by a reciprocal multiplication in ST_REDUCE; a table
// write is done there, after which the sequencer returns to idle.
// A sprite then issues one table read per cycle through the single read port
// of the table RAM while the read stage can move on; each read passes the read
// stage and the output register before its command is presented.
// tready is high only while the sequencer is idle; it returns as soon as the
// last table read of a sprite is issued, while earlier commands still drain.
// When the receiver stalls, the output register and one read stage hold their
// commands and no further reads are issued until the output frees up.
// Reset returns the sequencer to idle and drops all pending commands; the
// table contents are undefined until written.
module sprite_entry_tile_expander_core #(
    parameter int TABLE_ENTRIES = 65536
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // table_index, table_value, attr_word0, attr_word1
    input  logic [sete_pkg::IN_BITS-1:0]  s_axis_tdata,
    // func
    input  logic [0:0]                    s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // tile_code, colour, flip_x, x_pos, y_pos, seven zero bits
    output logic [sete_pkg::OUT_BITS-1:0] m_axis_tdata,
    output logic                          m_axis_tlast
);

    import sete_pkg::*;

    localparam int AW          = $clog2(TABLE_ENTRIES);
    localparam int QW          = INDEX_BITS + 1 - AW;
    localparam int RW          = 25;
    localparam int RECIP_SHIFT = 32;
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << RECIP_SHIFT) + 64'(TABLE_ENTRIES) - 64'd1) / 64'(TABLE_ENTRIES);
    localparam logic [RW-1:0] RECIP    = RW'(RECIP_FULL);
    localparam logic [AW:0]   MOD      = (AW + 1)'(TABLE_ENTRIES);
    localparam logic [AW-1:0] SLOT_MAX = AW'(TABLE_ENTRIES - 1);
    localparam int CW = 1;
    localparam logic [CW-1:0] CNT_LAST = 1'b1;

    sete_state_t           state_reg, state_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic                  func_reg, func_next;
    logic [INDEX_BITS-1:0] idx_reg, idx_next;
    logic [QW-1:0]         quot_reg, quot_next;
    logic [CODE_BITS-1:0]  value_reg, value_next;
    logic [SIZE_BITS-1:0]  wf_reg, wf_next;
    logic [SIZE_BITS-1:0]  hf_reg, hf_next;
    logic [SIZE_BITS-1:0]  col_reg, col_next;
    logic [SIZE_BITS-1:0]  row_reg, row_next;
    logic [COLOR_BITS-1:0] colour_reg, colour_next;
    logic                  flip_reg, flip_next;
    logic [POS_BITS-1:0]   xb_reg, xb_next;
    logic [POS_BITS-1:0]   px_reg, px_next;
    logic [POS_BITS-1:0]   py_reg, py_next;
    logic [INDEX_BITS-1:0] tile_reg, tile_next;
    logic [AW-1:0]         slot_reg, slot_next;

    logic                  p1_valid_reg, p1_valid_next;
    tile_side_t            p1_side_reg, p1_side_next;
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_BITS-1:0]   out_data_reg, out_data_next;
    logic                  out_last_reg, out_last_next;

    logic [INDEX_BITS+RW-1:0] prod;
    logic [QW+AW:0]           qprod;
    logic [INDEX_BITS-1:0]    remv;
    logic [AW-1:0]            reduced;
    logic                  accept;
    logic                  p1_move;
    logic                  issue;
    logic                  last_tile;
    logic                  wr_en;
    logic [CODE_BITS-1:0]  rd_data;
    logic [POS_BITS-1:0]   x_in;
    logic [SIZE_BITS-1:0]  wf_in;

    sete_ram #(
        .WIDTH (CODE_BITS),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (reduced),
        .wr_data (value_reg),
        .rd_en   (issue),
        .rd_addr (slot_reg),
        .rd_data (rd_data)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    // The rounded-up reciprocal gives the exact quotient for every 16-bit index.
    assign prod    = {{RW{1'b0}}, idx_reg} * {{INDEX_BITS{1'b0}}, RECIP};
    assign qprod   = {{(AW + 1){1'b0}}, quot_reg} * {{QW{1'b0}}, MOD};
    assign remv    = idx_reg - qprod[INDEX_BITS-1:0];
    assign reduced = remv[AW-1:0];

    assign p1_move   = p1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign issue     = (state_reg == ST_EMIT) && (!p1_valid_reg || p1_move);
    assign last_tile = (col_reg == wf_reg) && (row_reg == hf_reg);
    assign wr_en     = (state_reg == ST_REDUCE) && (cnt_reg == CNT_LAST) && !func_reg;

    assign x_in  = s_axis_tdata[32 +: POS_BITS];
    assign wf_in = s_axis_tdata[41 +: SIZE_BITS];

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        func_next   = func_reg;
        idx_next    = idx_reg;
        quot_next   = quot_reg;
        value_next  = value_reg;
        wf_next     = wf_reg;
        hf_next     = hf_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        colour_next = colour_reg;
        flip_next   = flip_reg;
        xb_next     = xb_reg;
        px_next     = px_reg;
        py_next     = py_reg;
        tile_next   = tile_reg;
        slot_next   = slot_reg;

        p1_side_next.colour = colour_reg;
        p1_side_next.flip_x = flip_reg;
        p1_side_next.x_pos  = px_reg;
        p1_side_next.y_pos  = py_reg;
        p1_side_next.last   = last_tile;
        if (!issue)
        begin
            p1_side_next = p1_side_reg;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    func_next   = s_axis_tuser[0];
                    value_next  = s_axis_tdata[16 +: CODE_BITS];
                    tile_next   = s_axis_tdata[64 +: INDEX_BITS];
                    idx_next    = s_axis_tuser[0] ? s_axis_tdata[64 +: INDEX_BITS]
                                                  : s_axis_tdata[0 +: INDEX_BITS];
                    cnt_next    = '0;
                    wf_next     = wf_in;
                    hf_next     = s_axis_tdata[57 +: SIZE_BITS];
                    py_next     = s_axis_tdata[48 +: POS_BITS];
                    colour_next = s_axis_tdata[88 +: COLOR_BITS];
                    flip_next   = s_axis_tdata[94];
                    if (s_axis_tdata[94])
                    begin
                        xb_next = x_in + {2'b00, wf_in, 4'b0000} - TILE_STEP;
                    end
                    else
                    begin
                        xb_next = x_in - TILE_STEP;
                    end
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                quot_next = prod[RECIP_SHIFT +: QW];
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    if (func_reg)
                    begin
                        slot_next  = reduced;
                        px_next    = xb_reg;
                        col_next   = '0;
                        row_next   = '0;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_EMIT:
            begin
                if (issue)
                begin
                    tile_next = tile_reg + 1'b1;
                    if ((tile_reg == '1) || (slot_reg == SLOT_MAX))
                    begin
                        slot_next = '0;
                    end
                    else
                    begin
                        slot_next = slot_reg + 1'b1;
                    end
                    if (col_reg == wf_reg)
                    begin
                        col_next = '0;
                        row_next = row_reg + 1'b1;
                        px_next  = xb_reg;
                        py_next  = py_reg + TILE_STEP;
                    end
                    else
                    begin
                        col_next = col_reg + 1'b1;
                        px_next  = flip_reg ? (px_reg - TILE_STEP) : (px_reg + TILE_STEP);
                    end
                    if (last_tile)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (issue)
        begin
            p1_valid_next = 1'b1;
        end
        else if (p1_move)
        begin
            p1_valid_next = 1'b0;
        end
        else
        begin
            p1_valid_next = p1_valid_reg;
        end

        out_data_next = out_data_reg;
        out_last_next = out_last_reg;
        if (p1_move)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {7'b0000000, p1_side_reg.y_pos, p1_side_reg.x_pos,
                              p1_side_reg.flip_x, p1_side_reg.colour, rd_data};
            out_last_next  = p1_side_reg.last;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            p1_valid_reg  <= p1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg      <= cnt_next;
        func_reg     <= func_next;
        idx_reg      <= idx_next;
        quot_reg     <= quot_next;
        value_reg    <= value_next;
        wf_reg       <= wf_next;
        hf_reg       <= hf_next;
        col_reg      <= col_next;
        row_reg      <= row_next;
        colour_reg   <= colour_next;
        flip_reg     <= flip_next;
        xb_reg       <= xb_next;
        px_reg       <= px_next;
        py_reg       <= py_next;
        tile_reg     <= tile_next;
        slot_reg     <= slot_next;
        p1_side_reg  <= p1_side_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

endmodule
